/* hdl/segment_window_clipper_macros.svh */
// assertion macros for the segment window clipper
`ifndef SEGMENT_WINDOW_CLIPPER_MACROS_SVH
`define SEGMENT_WINDOW_CLIPPER_MACROS_SVH
`ifndef SYNTHESIS
`define SWC_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SWC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SWC_ASSERT_IMPLIES(label, ante, cons, msg)
`define SWC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* hdl/swc_pkg.sv */
// types and constants shared by the segment window clipper
package swc_pkg;
	localparam int COORD_BITS = 24;
	localparam int MAG_BITS = COORD_BITS;
	localparam int PROD_BITS = 2 * MAG_BITS;
	localparam int VAL_BITS = PROD_BITS + 3;
	localparam int LO_BITS = (MAG_BITS + 1) / 2;
	localparam int HI_BITS = MAG_BITS - LO_BITS;
	localparam int NUM_LANES = 4;
	localparam int LANE_LEFT = 0;
	localparam int LANE_RIGHT = 1;
	localparam int LANE_BOTTOM = 2;
	localparam int LANE_TOP = 3;
	localparam int RESOLVE_STAGES = 4;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COORD_BITS:0] diff_t;
	typedef logic [MAG_BITS-1:0] mag_t;
	typedef logic [PROD_BITS-1:0] prod_t;
	typedef logic signed [VAL_BITS-1:0] value_t;

	localparam coord_t WIN_LEFT_RESET = coord_t'(0);
	localparam coord_t WIN_RIGHT_RESET = coord_t'(163840);
	localparam coord_t WIN_BOTTOM_RESET = coord_t'(0);
	localparam coord_t WIN_TOP_RESET = coord_t'(122880);

	typedef enum logic [1:0] {
		REG_WIN_LEFT,
		REG_WIN_RIGHT,
		REG_WIN_BOTTOM,
		REG_WIN_TOP
	} cfg_reg_t;

	typedef struct packed {
		logic mode;
		coord_t first_x;
		coord_t first_y;
		coord_t second_x;
		coord_t second_y;
	} clip_in_t;

	typedef struct packed {
		coord_t clip_first_x;
		coord_t clip_first_y;
		coord_t clip_second_x;
		coord_t clip_second_y;
		logic visible;
	} clip_out_t;

	typedef struct packed {
		coord_t left;
		coord_t right;
		coord_t bottom;
		coord_t top;
	} win_t;

	typedef struct packed {
		logic mode;
		coord_t vx;
		coord_t vy;
		coord_t mx;
		coord_t my;
		logic reject;
		logic dx_zero;
		logic dy_zero;
		logic dx_pos;
		logic my_lt;
		logic my_gt;
	} ctx_t;

	typedef struct packed {
		mag_t num;
		mag_t fac;
		mag_t den;
		logic neg;
	} lane_op_t;

	typedef struct packed {
		prod_t sh;
		mag_t rem;
		mag_t den;
		logic neg;
	} div_lane_t;
endpackage

/* hdl/swc_prep.sv */
// operand preparation: differences, edge flags, magnitudes and signs
module swc_prep import swc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_vld,
	input clip_in_t in_item,
	input win_t win,
	output logic out_vld,
	output ctx_t out_ctx,
	output lane_op_t out_lane [NUM_LANES]
);
	function automatic mag_t abs_mag(diff_t d);
		diff_t a;
		a = d[COORD_BITS] ? -d : d;
		return a[MAG_BITS-1:0];
	endfunction

	logic vld_s1, vld_s2;
	ctx_t ctx_s1, ctx_s2;
	diff_t dx_s1, dy_s1, dl_s1, dr_s1, db_s1, dt_s1;
	lane_op_t lane_s2 [NUM_LANES];
	ctx_t ctx_d;

	always_comb begin
		ctx_d.mode = in_item.mode;
		ctx_d.vx = in_item.first_x;
		ctx_d.vy = in_item.first_y;
		ctx_d.mx = in_item.second_x;
		ctx_d.my = in_item.second_y;
		ctx_d.reject = (in_item.first_y > win.top && in_item.second_y > win.top) ||
			(in_item.first_y < win.bottom && in_item.second_y < win.bottom) ||
			(in_item.first_x > win.right && in_item.second_x > win.right) ||
			(in_item.first_x < win.left && in_item.second_x < win.left);
		ctx_d.dx_zero = (in_item.second_x == in_item.first_x);
		ctx_d.dy_zero = (in_item.second_y == in_item.first_y);
		ctx_d.dx_pos = (in_item.second_x > in_item.first_x);
		ctx_d.my_lt = (in_item.second_y < in_item.first_y);
		ctx_d.my_gt = (in_item.second_y > in_item.first_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s1 <= ctx_d;
		dx_s1 <= diff_t'(in_item.second_x) - diff_t'(in_item.first_x);
		dy_s1 <= diff_t'(in_item.second_y) - diff_t'(in_item.first_y);
		dl_s1 <= diff_t'(win.left) - diff_t'(in_item.first_x);
		dr_s1 <= diff_t'(win.right) - diff_t'(in_item.first_x);
		db_s1 <= diff_t'(win.bottom) - diff_t'(in_item.first_y);
		dt_s1 <= diff_t'(win.top) - diff_t'(in_item.first_y);
	end

	always_ff @(posedge clk) begin
		ctx_s2 <= ctx_s1;
		lane_s2[LANE_LEFT].num <= abs_mag(dy_s1);
		lane_s2[LANE_LEFT].fac <= abs_mag(dl_s1);
		lane_s2[LANE_LEFT].den <= abs_mag(dx_s1);
		lane_s2[LANE_LEFT].neg <= dy_s1[COORD_BITS] ^ dl_s1[COORD_BITS] ^ dx_s1[COORD_BITS];
		lane_s2[LANE_RIGHT].num <= abs_mag(dy_s1);
		lane_s2[LANE_RIGHT].fac <= abs_mag(dr_s1);
		lane_s2[LANE_RIGHT].den <= abs_mag(dx_s1);
		lane_s2[LANE_RIGHT].neg <= dy_s1[COORD_BITS] ^ dr_s1[COORD_BITS] ^ dx_s1[COORD_BITS];
		lane_s2[LANE_BOTTOM].num <= abs_mag(dx_s1);
		lane_s2[LANE_BOTTOM].fac <= abs_mag(db_s1);
		lane_s2[LANE_BOTTOM].den <= abs_mag(dy_s1);
		lane_s2[LANE_BOTTOM].neg <= dx_s1[COORD_BITS] ^ db_s1[COORD_BITS] ^ dy_s1[COORD_BITS];
		lane_s2[LANE_TOP].num <= abs_mag(dx_s1);
		lane_s2[LANE_TOP].fac <= abs_mag(dt_s1);
		lane_s2[LANE_TOP].den <= abs_mag(dy_s1);
		lane_s2[LANE_TOP].neg <= dx_s1[COORD_BITS] ^ dt_s1[COORD_BITS] ^ dy_s1[COORD_BITS];
	end

	assign out_vld = vld_s2;
	assign out_ctx = ctx_s2;
	assign out_lane = lane_s2;
endmodule

/* hdl/swc_mul.sv */
// four-lane magnitude multiplier, split partial products over two stages
module swc_mul import swc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_vld,
	input ctx_t in_ctx,
	input lane_op_t in_lane [NUM_LANES],
	output logic out_vld,
	output ctx_t out_ctx,
	output div_lane_t out_lane [NUM_LANES]
);
	logic vld_s1, vld_s2;
	ctx_t ctx_s1, ctx_s2;
	logic [2*LO_BITS-1:0] p00_s1 [NUM_LANES];
	logic [LO_BITS+HI_BITS-1:0] p01_s1 [NUM_LANES];
	logic [LO_BITS+HI_BITS-1:0] p10_s1 [NUM_LANES];
	logic [2*HI_BITS-1:0] p11_s1 [NUM_LANES];
	mag_t den_s1 [NUM_LANES];
	logic [NUM_LANES-1:0] neg_s1;
	div_lane_t lane_s2 [NUM_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s1 <= in_ctx;
		for (int l = 0; l < NUM_LANES; l++) begin
			p00_s1[l] <= (2*LO_BITS)'(in_lane[l].num[LO_BITS-1:0]) *
				(2*LO_BITS)'(in_lane[l].fac[LO_BITS-1:0]);
			p01_s1[l] <= (LO_BITS+HI_BITS)'(in_lane[l].num[LO_BITS-1:0]) *
				(LO_BITS+HI_BITS)'(in_lane[l].fac[MAG_BITS-1:LO_BITS]);
			p10_s1[l] <= (LO_BITS+HI_BITS)'(in_lane[l].num[MAG_BITS-1:LO_BITS]) *
				(LO_BITS+HI_BITS)'(in_lane[l].fac[LO_BITS-1:0]);
			p11_s1[l] <= (2*HI_BITS)'(in_lane[l].num[MAG_BITS-1:LO_BITS]) *
				(2*HI_BITS)'(in_lane[l].fac[MAG_BITS-1:LO_BITS]);
			den_s1[l] <= in_lane[l].den;
			neg_s1[l] <= in_lane[l].neg;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s2 <= ctx_s1;
		for (int l = 0; l < NUM_LANES; l++) begin
			lane_s2[l].sh <= (prod_t'(p11_s1[l]) << (2*LO_BITS)) +
				((prod_t'(p01_s1[l]) + prod_t'(p10_s1[l])) << LO_BITS) +
				prod_t'(p00_s1[l]);
			lane_s2[l].rem <= '0;
			lane_s2[l].den <= den_s1[l];
			lane_s2[l].neg <= neg_s1[l];
		end
	end

	assign out_vld = vld_s2;
	assign out_ctx = ctx_s2;
	assign out_lane = lane_s2;
endmodule

/* hdl/swc_div.sv */
// pipelined restoring divider, one quotient bit per stage on four lanes
module swc_div import swc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_vld,
	input ctx_t in_ctx,
	input div_lane_t in_lane [NUM_LANES],
	output logic out_vld,
	output ctx_t out_ctx,
	output div_lane_t out_lane [NUM_LANES]
);
	logic [PROD_BITS-1:0] vld_s;
	ctx_t ctx_s [PROD_BITS];
	div_lane_t dv_s [PROD_BITS][NUM_LANES];
	div_lane_t cur [PROD_BITS][NUM_LANES];
	div_lane_t nxt [PROD_BITS][NUM_LANES];

	always_comb begin
		logic [MAG_BITS:0] trial;
		logic [MAG_BITS:0] rest;
		logic ge;
		for (int l = 0; l < NUM_LANES; l++) begin
			cur[0][l] = in_lane[l];
		end
		for (int k = 1; k < PROD_BITS; k++) begin
			cur[k] = dv_s[k-1];
		end
		for (int k = 0; k < PROD_BITS; k++) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				trial = {cur[k][l].rem, cur[k][l].sh[PROD_BITS-1]};
				rest = trial - {1'b0, cur[k][l].den};
				ge = (trial >= {1'b0, cur[k][l].den});
				nxt[k][l].rem = ge ? rest[MAG_BITS-1:0] : trial[MAG_BITS-1:0];
				nxt[k][l].sh = {cur[k][l].sh[PROD_BITS-2:0], ge};
				nxt[k][l].den = cur[k][l].den;
				nxt[k][l].neg = cur[k][l].neg;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[PROD_BITS-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		ctx_s[0] <= in_ctx;
		for (int k = 1; k < PROD_BITS; k++) begin
			ctx_s[k] <= ctx_s[k-1];
		end
		dv_s <= nxt;
	end

	assign out_vld = vld_s[PROD_BITS-1];
	assign out_ctx = ctx_s[PROD_BITS-1];
	assign out_lane = dv_s[PROD_BITS-1];
endmodule

/* hdl/swc_resolve.sv */
// rounding, edge tests and endpoint selection
module swc_resolve import swc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_vld,
	input ctx_t in_ctx,
	input div_lane_t in_lane [NUM_LANES],
	input win_t win,
	output logic done,
	output clip_out_t result
);
	localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_BITS-1){1'b1}}});
	localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_BITS-1){1'b0}}});

	function automatic coord_t sat_coord(value_t v);
		if (v > value_t'(COORD_MAX)) begin
			return COORD_MAX;
		end else if (v < value_t'(COORD_MIN)) begin
			return COORD_MIN;
		end
		return coord_t'(v[COORD_BITS-1:0]);
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	ctx_t ctx_s1, ctx_s2, ctx_s3;
	logic [PROD_BITS:0] quo_s1 [NUM_LANES];
	logic [NUM_LANES-1:0] neg_s1;
	value_t val_s2 [NUM_LANES];
	value_t val_d [NUM_LANES];
	value_t lo_b [NUM_LANES];
	value_t hi_b [NUM_LANES];
	coord_t sat_s3 [NUM_LANES];
	logic [NUM_LANES-1:0] ge_s3, le_s3;
	clip_out_t res_d, result_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// round to nearest, ties away from zero
	always_ff @(posedge clk) begin
		ctx_s1 <= in_ctx;
		for (int l = 0; l < NUM_LANES; l++) begin
			quo_s1[l] <= {1'b0, in_lane[l].sh} +
				(PROD_BITS+1)'({in_lane[l].rem, 1'b0} >= {1'b0, in_lane[l].den});
			neg_s1[l] <= in_lane[l].neg;
		end
	end

	always_comb begin
		value_t q;
		value_t base;
		for (int l = 0; l < NUM_LANES; l++) begin
			q = value_t'(quo_s1[l]);
			base = (l == LANE_LEFT || l == LANE_RIGHT) ? value_t'(ctx_s1.vy) :
				value_t'(ctx_s1.vx);
			val_d[l] = base + (neg_s1[l] ? -q : q);
			lo_b[l] = (l == LANE_LEFT || l == LANE_RIGHT) ? value_t'(win.bottom) :
				value_t'(win.left);
			hi_b[l] = (l == LANE_LEFT || l == LANE_RIGHT) ? value_t'(win.top) :
				value_t'(win.right);
		end
	end

	always_ff @(posedge clk) begin
		ctx_s2 <= ctx_s1;
		val_s2 <= val_d;
	end

	always_ff @(posedge clk) begin
		ctx_s3 <= ctx_s2;
		for (int l = 0; l < NUM_LANES; l++) begin
			ge_s3[l] <= (val_s2[l] >= lo_b[l]);
			le_s3[l] <= (val_s2[l] <= hi_b[l]);
			sat_s3[l] <= sat_coord(val_s2[l]);
		end
	end

	always_comb begin
		coord_t fx, fy, sx, sy, ysel, xsel;
		logic vis, x_lt, x_gt;
		logic [NUM_LANES-1:0] hit;
		fx = ctx_s3.vx;
		fy = ctx_s3.vy;
		sx = ctx_s3.mx;
		sy = ctx_s3.my;
		vis = 1'b1;
		hit = ge_s3 & le_s3;
		ysel = ctx_s3.my_lt ? win.bottom : (ctx_s3.my_gt ? win.top : ctx_s3.vy);
		xsel = ctx_s3.my_lt ? sat_s3[LANE_BOTTOM] : sat_s3[LANE_TOP];
		x_lt = ctx_s3.my_lt ? !ge_s3[LANE_BOTTOM] : !ge_s3[LANE_TOP];
		x_gt = ctx_s3.my_lt ? !le_s3[LANE_BOTTOM] : !le_s3[LANE_TOP];
		priority if (ctx_s3.mode) begin
			priority if (ctx_s3.dx_zero) begin
				sy = ysel;
			end else if (ctx_s3.dy_zero) begin
				sx = ctx_s3.dx_pos ? win.right : win.left;
				sy = ctx_s3.vy;
			end else if (x_lt) begin
				sx = win.left;
				sy = sat_s3[LANE_LEFT];
			end else if (x_gt) begin
				sx = win.right;
				sy = sat_s3[LANE_RIGHT];
			end else begin
				sx = xsel;
				sy = ysel;
			end
		end else if (ctx_s3.reject) begin
			vis = 1'b0;
		end else if (ctx_s3.dx_zero) begin
			fy = ctx_s3.my_gt ? win.bottom : win.top;
			sy = ctx_s3.my_gt ? win.top : win.bottom;
		end else if (ctx_s3.dy_zero) begin
			fx = ctx_s3.dx_pos ? win.left : win.right;
			sx = ctx_s3.dx_pos ? win.right : win.left;
		end else begin
			if (hit[LANE_LEFT]) begin
				fx = win.left;
				fy = sat_s3[LANE_LEFT];
			end
			if (hit[LANE_RIGHT]) begin
				if (hit[LANE_LEFT]) begin
					sx = win.right;
					sy = sat_s3[LANE_RIGHT];
				end else begin
					fx = win.right;
					fy = sat_s3[LANE_RIGHT];
				end
			end
			if (hit[LANE_BOTTOM]) begin
				if (hit[LANE_LEFT] || hit[LANE_RIGHT]) begin
					sx = sat_s3[LANE_BOTTOM];
					sy = win.bottom;
				end else begin
					fx = sat_s3[LANE_BOTTOM];
					fy = win.bottom;
				end
			end
			if (hit[LANE_TOP]) begin
				sx = sat_s3[LANE_TOP];
				sy = win.top;
			end
			vis = ((3'(hit[LANE_LEFT]) + 3'(hit[LANE_RIGHT]) + 3'(hit[LANE_BOTTOM]) +
				3'(hit[LANE_TOP])) == 3'd2);
		end
		if (!vis) begin
			fx = '0;
			fy = '0;
			sx = '0;
			sy = '0;
		end
		res_d.clip_first_x = fx;
		res_d.clip_first_y = fy;
		res_d.clip_second_x = sx;
		res_d.clip_second_y = sy;
		res_d.visible = vis;
	end

	always_ff @(posedge clk) begin
		result_s4 <= res_d;
	end

	assign done = vld_s4;
	assign result = result_s4;
endmodule

/* hdl/segment_window_clipper.sv */
// top level of the segment window clipper
//
// one segment item enters on start while busy is low; busy is high only in
// the first cycle after reset and low from then on, so an item may enter in
// every cycle. four window edges are written through cfg_wr_en, cfg_index
// and cfg_data; the user must write them only while no item is in flight,
// which the block does not enforce. the result item is shown on result
// for one cycle, marked by done, after the item has passed the input
// register and the prep, multiply, divider and resolve stages: one quotient
// bit per divider stage over the 2*COORD_BITS bit product, plus two prep,
// two multiply and four resolve stages. throughput is one item per cycle.
// reset clears every valid bit and loads the default window; items in
// flight are dropped. the receiver cannot stall: a result is taken in the
// cycle it is shown.
`include "segment_window_clipper_macros.svh"
module segment_window_clipper import swc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input clip_in_t item,
	output logic done,
	output clip_out_t result,
	input logic cfg_wr_en,
	input logic [1:0] cfg_index,
	input coord_t cfg_data
);
	win_t win_q;
	logic busy_q;
	logic vld_s1;
	clip_in_t item_s1;
	logic prep_vld, mul_vld, div_vld;
	ctx_t prep_ctx, mul_ctx, div_ctx;
	lane_op_t prep_lane [NUM_LANES];
	div_lane_t mul_lane [NUM_LANES];
	div_lane_t div_lane [NUM_LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			win_q.left <= WIN_LEFT_RESET;
			win_q.right <= WIN_RIGHT_RESET;
			win_q.bottom <= WIN_BOTTOM_RESET;
			win_q.top <= WIN_TOP_RESET;
		end else begin
			busy_q <= 1'b0;
			if (cfg_wr_en) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_WIN_LEFT: win_q.left <= cfg_data;
					REG_WIN_RIGHT: win_q.right <= cfg_data;
					REG_WIN_BOTTOM: win_q.bottom <= cfg_data;
					REG_WIN_TOP: win_q.top <= cfg_data;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy_q;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item;
	end

	assign busy = busy_q;

	swc_prep u_prep (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(vld_s1),
		.in_item(item_s1),
		.win(win_q),
		.out_vld(prep_vld),
		.out_ctx(prep_ctx),
		.out_lane(prep_lane)
	);

	swc_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(prep_vld),
		.in_ctx(prep_ctx),
		.in_lane(prep_lane),
		.out_vld(mul_vld),
		.out_ctx(mul_ctx),
		.out_lane(mul_lane)
	);

	swc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(mul_vld),
		.in_ctx(mul_ctx),
		.in_lane(mul_lane),
		.out_vld(div_vld),
		.out_ctx(div_ctx),
		.out_lane(div_lane)
	);

	swc_resolve u_resolve (
		.clk(clk),
		.arst_n(arst_n),
		.in_vld(div_vld),
		.in_ctx(div_ctx),
		.in_lane(div_lane),
		.win(win_q),
		.done(done),
		.result(result)
	);

	`SWC_ASSERT_NEXT(a_busy_once, busy, !busy, "busy held past first cycle")
	`SWC_ASSERT_IMPLIES(a_mode1_visible, done && $past(div_ctx.mode, RESOLVE_STAGES), result.visible, "first-inside item not visible")
	`SWC_ASSERT_IMPLIES(a_reject_hidden, done && $past(!div_ctx.mode && div_ctx.reject, RESOLVE_STAGES), !result.visible, "rejected item shown visible")
	`SWC_ASSERT_IMPLIES(a_hidden_zero, done && !result.visible, result.clip_first_x == '0 && result.clip_first_y == '0 && result.clip_second_x == '0 && result.clip_second_y == '0, "hidden item has nonzero endpoints")
endmodule
